// ===== src/bpa_pkg.sv =====
// Shared constants, request codes and controller state type for the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

    // Page numbers inside the block: the managed page count never exceeds 8191.
    localparam int PAGE_W     = 13;
    localparam int OUT_PAGE_W = 12;
    localparam int COUNT_W    = 13;
    localparam int KIND_W     = 2;

    localparam int DEF_MAX_PAGES = 4096;
    localparam int PAGE_LIMIT    = 8191;
    localparam int WIDE_WORD     = 64;
    localparam int NARROW_WORD   = 8;

    localparam logic [COUNT_W-1:0] CFG_RESET = 13'd4096;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SEEK,
        ST_RUN,
        ST_MARK_RD,
        ST_MARK
    } t_state;

endpackage

// ===== src/bpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bpa_word_scan.sv =====
// Finds the lowest free or used page of one map word at or above a bit position.
`timescale 1ns / 1ps
module bpa_word_scan #(
    parameter int W = 64,
    localparam int LW = $clog2(W)
) (
    input  logic [W-1:0]                i_word,
    input  logic [LW-1:0]               i_pos,
    input  logic [bpa_pkg::PAGE_W-1:0]  i_rem,
    input  logic                        i_find_free,
    output logic                        o_found,
    output logic [LW-1:0]               o_idx
);
    import bpa_pkg::*;

    logic [W-1:0] beyond;
    logic [W-1:0] used;
    logic [W-1:0] cand;

    always_comb begin
        // pages at or past the limit count as used, so no run crosses the end
        if (i_rem >= PAGE_W'(W)) begin
            beyond = '0;
        end else begin
            beyond = {W{1'b1}} << i_rem[LW-1:0];
        end
        used = i_word | beyond;
        cand = (i_find_free ? ~used : used) & ({W{1'b1}} << i_pos);
    end

    always_comb begin
        o_idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_idx = LW'(i);
            end
        end
        o_found = |cand;
    end

endmodule

// ===== src/bitmap_page_allocator_top.sv =====
// Top level of the bitmap first-fit page allocator: controller, word scan and map memory.
`timescale 1ns / 1ps
// Usage
//   Requests enter on start/i_kind/i_start_page/i_page_count and are taken at a clock
//   edge with start high and busy low. Each transaction yields exactly one result,
//   shown for one cycle with o_done high on o_granted_page and o_ok. The receiver
//   cannot stall; busy drops in the cycle the result is shown, so a new transaction
//   may be started in that same cycle.
//   i_cfg_we/i_cfg_wdata write the managed page count; write it only while idle.
// Sequence (W = 64 pages per map word at the default size)
//   Unknown kind or empty range: result in the cycle after the start.
//   Reserve/release: each map word the range touches is read, then written back.
//   Allocate: map words are scanned in turn, with one step per free/used boundary met
//   inside a word; a granted run with a nonzero count then marks its words. The single read
//   port of the map memory sets the pace: one word, or one boundary, per cycle.
// Reset
//   The map memory is swept to all free, one word per cycle; busy stays high during
//   the sweep. The page count resets to 4096.
module bitmap_page_allocator_top #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [bpa_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic [bpa_pkg::KIND_W-1:0]      i_kind,
    input  logic [bpa_pkg::OUT_PAGE_W-1:0]  i_start_page,
    input  logic [bpa_pkg::COUNT_W-1:0]     i_page_count,
    output logic                            o_done,
    output logic [bpa_pkg::OUT_PAGE_W-1:0]  o_granted_page,
    output logic                            o_ok
);
    import bpa_pkg::*;

    localparam int W      = (MAX_PAGES >= WIDE_WORD) ? WIDE_WORD : NARROW_WORD;
    localparam int LW     = $clog2(W);
    localparam int DEPTH  = (MAX_PAGES + W - 1) / W;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDXW   = PAGE_W - LW;
    localparam int CLIP_I = (MAX_PAGES > PAGE_LIMIT) ? PAGE_LIMIT : MAX_PAGES;
    localparam logic [PAGE_W-1:0] MAX_CLIP = PAGE_W'(CLIP_I);

    t_state r_state, n_state;
    logic [COUNT_W-1:0]    r_cfg;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [PAGE_W-1:0]     r_lo, n_lo;
    logic [PAGE_W-1:0]     r_hi, n_hi;
    logic                  r_val, n_val;
    logic                  r_ok_pend, n_ok_pend;
    logic [PAGE_W-1:0]     r_gnt, n_gnt;
    logic [IDXW-1:0]       r_widx, n_widx;
    logic [LW-1:0]         r_pos, n_pos;
    logic [PAGE_W:0]       r_run, n_run;
    logic [AW-1:0]         r_clr, n_clr;
    logic                  r_done, n_done;
    logic                  r_ok, n_ok;
    logic [OUT_PAGE_W-1:0] r_granted, n_granted;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [W-1:0]          ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [W-1:0]          ram_rdata;

    logic [PAGE_W-1:0]     limit;
    logic [PAGE_W-1:0]     base;
    logic [PAGE_W:0]       nbase;
    logic                  next_end;
    logic [PAGE_W-1:0]     rem;
    logic                  scan_found;
    logic [LW-1:0]         scan_idx;
    logic [PAGE_W:0]       run_len;
    logic [PAGE_W:0]       req_sum;
    logic                  req_fits;
    logic [PAGE_W-1:0]     req_hi;
    logic [PAGE_W-1:0]     hi_m1;
    logic [LW-1:0]         lo_bit;
    logic [LW-1:0]         hi_bit;
    logic [W-1:0]          bit_mask;
    logic [W-1:0]          mark_word;
    logic [IDXW-1:0]       widx_inc;

    bpa_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpa_word_scan #(
        .W (W)
    ) u_scan (
        .i_word      (ram_rdata),
        .i_pos       (r_pos),
        .i_rem       (rem),
        .i_find_free (r_state == ST_SEEK),
        .o_found     (scan_found),
        .o_idx       (scan_idx)
    );

    // datapath helpers
    always_comb begin
        limit    = (r_cfg > MAX_CLIP) ? MAX_CLIP : r_cfg;
        base     = {r_widx, {LW{1'b0}}};
        nbase    = {1'b0, base} + (PAGE_W + 1)'(W);
        next_end = nbase >= {1'b0, limit};
        rem      = limit - base;
        widx_inc = r_widx + IDXW'(1);

        if (scan_found) begin
            run_len = r_run + {{(PAGE_W + 1 - LW){1'b0}}, scan_idx}
                      - {{(PAGE_W + 1 - LW){1'b0}}, r_pos};
        end else begin
            run_len = r_run + (PAGE_W + 1)'(W) - {{(PAGE_W + 1 - LW){1'b0}}, r_pos};
        end

        req_sum  = {2'b00, i_start_page} + {1'b0, i_page_count};
        req_fits = req_sum <= {1'b0, limit};
        req_hi   = req_fits ? req_sum[PAGE_W-1:0] : limit;

        // bit span of the current word inside [r_lo, r_hi)
        hi_m1     = r_hi - PAGE_W'(1);
        lo_bit    = (r_widx == r_lo[PAGE_W-1:LW]) ? r_lo[LW-1:0] : '0;
        hi_bit    = (r_widx == hi_m1[PAGE_W-1:LW]) ? hi_m1[LW-1:0] : '1;
        bit_mask  = ({W{1'b1}} << lo_bit) & ({W{1'b1}} >> (LW'(W - 1) - hi_bit));
        mark_word = r_val ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_cfg   <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_val     <= n_val;
        r_ok_pend <= n_ok_pend;
        r_gnt     <= n_gnt;
        r_widx    <= n_widx;
        r_pos     <= n_pos;
        r_run     <= n_run;
        r_ok      <= n_ok;
        r_granted <= n_granted;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_val     = r_val;
        n_ok_pend = r_ok_pend;
        n_gnt     = r_gnt;
        n_widx    = r_widx;
        n_pos     = r_pos;
        n_run     = r_run;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_ok      = r_ok;
        n_granted = r_granted;

        ram_we    = 1'b0;
        ram_waddr = AW'(r_widx);
        ram_wdata = mark_word;
        ram_re    = 1'b0;
        ram_raddr = AW'(r_widx);

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            ST_IDLE: begin
                if (start) begin
                    case (i_kind)
                        KIND_ALLOC: begin
                            n_count = i_page_count;
                            n_widx  = '0;
                            n_pos   = '0;
                            n_state = ST_SCAN_RD;
                        end
                        KIND_RESERVE, KIND_RELEASE: begin
                            if ({1'b0, i_start_page} < req_hi) begin
                                n_lo      = {1'b0, i_start_page};
                                n_hi      = req_hi;
                                n_val     = (i_kind == KIND_RESERVE);
                                n_ok_pend = req_fits;
                                n_gnt     = '0;
                                n_widx    = IDXW'(i_start_page[OUT_PAGE_W-1:LW]);
                                n_state   = ST_MARK_RD;
                            end else begin
                                // a zero-length range always succeeds
                                n_done    = 1'b1;
                                n_ok      = req_fits || (i_page_count == '0);
                                n_granted = '0;
                            end
                        end
                        default: begin
                            n_done    = 1'b1;
                            n_ok      = 1'b0;
                            n_granted = '0;
                        end
                    endcase
                end
            end

            ST_SCAN_RD: begin
                if (limit == '0) begin
                    n_done    = 1'b1;
                    n_ok      = 1'b0;
                    n_granted = '0;
                    n_state   = ST_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_SEEK;
                end
            end

            ST_SEEK: begin
                if (scan_found) begin
                    if (r_count == '0) begin
                        n_done    = 1'b1;
                        n_ok      = 1'b1;
                        n_granted = OUT_PAGE_W'({r_widx, scan_idx});
                        n_state   = ST_IDLE;
                    end else begin
                        n_lo    = {r_widx, scan_idx};
                        n_pos   = scan_idx;
                        n_run   = '0;
                        n_state = ST_RUN;
                    end
                end else if (next_end) begin
                    n_done    = 1'b1;
                    n_ok      = 1'b0;
                    n_granted = '0;
                    n_state   = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(widx_inc);
                    n_widx    = widx_inc;
                    n_pos     = '0;
                end
            end

            ST_RUN: begin
                if (run_len >= {1'b0, r_count}) begin
                    // run long enough: mark it from its first page
                    n_hi      = r_lo + r_count;
                    n_gnt     = r_lo;
                    n_val     = 1'b1;
                    n_ok_pend = 1'b1;
                    n_widx    = r_lo[PAGE_W-1:LW];
                    n_state   = ST_MARK_RD;
                end else if (scan_found) begin
                    n_pos   = scan_idx;
                    n_state = ST_SEEK;
                end else if (next_end) begin
                    n_done    = 1'b1;
                    n_ok      = 1'b0;
                    n_granted = '0;
                    n_state   = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(widx_inc);
                    n_widx    = widx_inc;
                    n_pos     = '0;
                    n_run     = run_len;
                end
            end

            ST_MARK_RD: begin
                ram_re  = 1'b1;
                n_state = ST_MARK;
            end

            ST_MARK: begin
                // write back this word while fetching the next one
                ram_we = 1'b1;
                if (r_widx == hi_m1[PAGE_W-1:LW]) begin
                    n_done    = 1'b1;
                    n_ok      = r_ok_pend;
                    n_granted = r_gnt[OUT_PAGE_W-1:0];
                    n_state   = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(widx_inc);
                    n_widx    = widx_inc;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_granted_page = r_granted;

endmodule

// ===== src/bpa_chk.sv =====
// Port-level checker for the bitmap page allocator, bound to the top level.
`timescale 1ns / 1ps
module bpa_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [bpa_pkg::KIND_W-1:0]      i_kind,
    input  logic                            o_done,
    input  logic [bpa_pkg::OUT_PAGE_W-1:0]  o_granted_page,
    input  logic                            o_ok
);
    import bpa_pkg::*;

    // a result is only shown once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // a failed transaction never reports a page
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_granted_page == '0))
        else $error("failed transaction carries a page");

    // an unknown request is rejected in the next cycle
    a_bad_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_INVALID) |=> (o_done && !o_ok))
        else $error("unknown request not rejected");

    // no result appears without a transaction in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_done)
        else $error("result without transaction");

endmodule

bind bitmap_page_allocator_top bpa_chk u_bpa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_kind         (i_kind),
    .o_done         (o_done),
    .o_granted_page (o_granted_page),
    .o_ok           (o_ok)
);

// ===== tb/bpa_grant_checker.sv =====
// Watches the allocator's channels, predicts each grant from a model of the used-page map and compares.
`timescale 1ns / 1ps
module bpa_grant_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_cfg_we,
    input  logic [bpa_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic [bpa_pkg::KIND_W-1:0]      i_kind,
    input  logic [bpa_pkg::OUT_PAGE_W-1:0]  i_start_page,
    input  logic [bpa_pkg::COUNT_W-1:0]     i_page_count,
    input  logic                            i_done,
    input  logic [bpa_pkg::OUT_PAGE_W-1:0]  i_granted_page,
    input  logic                            i_ok,
    output int                              o_mismatches,
    output int                              o_pending
);
    import bpa_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OUT_PAGE_W-1:0] page;
        logic                  ok;
    } t_grant;

    t_grant             grant_queue[$];
    bit                 page_used[DEF_MAX_PAGES];
    logic [COUNT_W-1:0] managed_cfg;
    int                 mismatch_count = 0;
    int                 pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    // The register saturates at the map size; zero manages nothing.
    function automatic int page_bound();
        return (int'(managed_cfg) > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(managed_cfg);
    endfunction

    // Set a run of pages; stop at the bound and report the cut.
    function automatic bit fill_pages(int first, int n, bit val);
        int lim;
        int p;
        lim = page_bound();
        for (int k = 0; k < n; k++) begin
            p = first + k;
            if (p >= lim)
                return 1'b0;
            page_used[p] = val;
        end
        return 1'b1;
    endfunction

    function automatic t_grant predict_grant(logic [KIND_W-1:0] kind,
                                             logic [OUT_PAGE_W-1:0] first,
                                             logic [COUNT_W-1:0] cnt);
        t_grant res;
        int     lim;
        int     run;
        int     run_start;
        res = '0;
        case (kind)
            KIND_ALLOC: begin
                lim       = page_bound();
                run       = 0;
                run_start = 0;
                for (int p = 0; p < lim; p++) begin
                    if (page_used[p]) begin
                        run = 0;
                    end else begin
                        if (run == 0)
                            run_start = p;
                        run++;
                        // first fit: a zero count is met by the lowest free page
                        if (run >= int'(cnt)) begin
                            void'(fill_pages(run_start, int'(cnt), 1'b1));
                            res.page = run_start[OUT_PAGE_W-1:0];
                            res.ok   = 1'b1;
                            break;
                        end
                    end
                end
            end
            KIND_RESERVE: res.ok = fill_pages(int'(first), int'(cnt), 1'b1);
            KIND_RELEASE: res.ok = fill_pages(int'(first), int'(cnt), 1'b0);
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(bit stray, t_grant want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            if (stray)
                $display("%0t: unexpected result page %0d ok %0b", $realtime,
                         i_granted_page, i_ok);
            else
                $display("%0t: mismatch: expected page %0d ok %0b, got page %0d ok %0b",
                         $realtime, want.page, want.ok, i_granted_page, i_ok);
        end
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            page_used   = '{default: 1'b0};
            managed_cfg = CFG_RESET;
            grant_queue.delete();
        end else begin
            // retire the older transaction before a new one is taken in the same cycle
            if (i_done) begin
                if (grant_queue.size() == 0) begin
                    report_mismatch(1'b1, '0);
                end else begin
                    want = grant_queue.pop_front();
                    if (want.page !== i_granted_page || want.ok !== i_ok)
                        report_mismatch(1'b0, want);
                end
            end
            if (i_cfg_we)
                managed_cfg = i_cfg_wdata;
            if (i_start && !i_busy)
                grant_queue.push_back(predict_grant(i_kind, i_start_page, i_page_count));
        end
        pending_count = grant_queue.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the page allocator testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;
    import bpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 190;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [COUNT_W-1:0]    i_cfg_wdata;
    logic [KIND_W-1:0]     i_kind;
    logic [OUT_PAGE_W-1:0] i_start_page;
    logic [COUNT_W-1:0]    i_page_count;
    logic                  o_done;
    logic [OUT_PAGE_W-1:0] o_granted_page;
    logic                  o_ok;
    int                    mismatches;
    int                    pending_results;
    int                    idle_cycles = 0;
    int                    burst_left  = 0;
    int                    cur_limit   = DEF_MAX_PAGES;

    bitmap_page_allocator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_start_page   (i_start_page),
        .i_page_count   (i_page_count),
        .o_done         (o_done),
        .o_granted_page (o_granted_page),
        .o_ok           (o_ok)
    );

    bpa_grant_checker grant_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_start_page   (i_start_page),
        .i_page_count   (i_page_count),
        .i_done         (o_done),
        .i_granted_page (o_granted_page),
        .i_ok           (o_ok),
        .o_mismatches   (mismatches),
        .o_pending      (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one transaction and hold it until taken; idle in bursts.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [OUT_PAGE_W-1:0] first,
                                logic [COUNT_W-1:0] cnt);
        if (!start)
            start <= 1'b1;
        i_kind       <= kind;
        i_start_page <= first;
        i_page_count <= cnt;
        do
            @(posedge i_clk);
        while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Drop start and wait for the block to drain and go quiet.
    task automatic settle();
        if (start)
            start <= 1'b0;
        @(negedge i_clk);
        while (busy !== 1'b0 || pending_results != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_page_limit(logic [COUNT_W-1:0] val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_limit = (int'(val) > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(val);
    endtask

    task automatic random_request();
        int                    span;
        int                    sel;
        logic [KIND_W-1:0]     kind;
        logic [OUT_PAGE_W-1:0] first;
        logic [COUNT_W-1:0]    cnt;
        span = (cur_limit == 0) ? 1 : cur_limit;
        sel  = $urandom_range(0, 99);
        kind = (sel < 45) ? KIND_ALLOC : (sel < 68) ? KIND_RESERVE :
               (sel < 95) ? KIND_RELEASE : KIND_INVALID;
        sel   = $urandom_range(0, 99);
        first = (sel < 85) ? OUT_PAGE_W'($urandom_range(0, span - 1))
                           : OUT_PAGE_W'($urandom_range(0, 4095));
        // mostly short runs that fit, some near or past the bound, a few anything
        sel = $urandom_range(0, 99);
        if (sel < 8)
            cnt = '0;
        else if (sel < 78)
            cnt = COUNT_W'($urandom_range(1, span / 8 + 1));
        else if (sel < 93)
            cnt = COUNT_W'($urandom_range(1, span + 4));
        else
            cnt = COUNT_W'($urandom_range(0, 8191));
        send_request(kind, first, cnt);
    endtask

    initial begin
        logic [COUNT_W-1:0] limits[8];
        limits = '{13'd1, 13'd8, 13'd0, 13'd64, 13'd8191, 13'd37, 13'd513, 13'd4096};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_kind       = KIND_ALLOC;
        i_start_page = '0;
        i_page_count = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // directed pass over the reset page count
        send_request(KIND_ALLOC,   12'd0,    13'd0);
        send_request(KIND_ALLOC,   12'd0,    13'd1);
        send_request(KIND_ALLOC,   12'd0,    13'd4096);
        send_request(KIND_RELEASE, 12'd0,    13'd1);
        send_request(KIND_ALLOC,   12'd0,    13'd4096);
        send_request(KIND_ALLOC,   12'd0,    13'd0);
        send_request(KIND_ALLOC,   12'd0,    13'd1);
        send_request(KIND_RELEASE, 12'd0,    13'd4096);
        send_request(KIND_RESERVE, 12'd4095, 13'd1);
        send_request(KIND_RESERVE, 12'd4095, 13'd2);
        send_request(KIND_RELEASE, 12'd4000, 13'd8191);
        send_request(KIND_RESERVE, 12'd100,  13'd0);
        send_request(KIND_RELEASE, 12'd0,    13'd0);
        send_request(KIND_INVALID, 12'd4095, 13'd8191);
        send_request(KIND_INVALID, 12'd0,    13'd0);
        send_request(KIND_RESERVE, 12'd0,    13'd10);
        send_request(KIND_ALLOC,   12'd0,    13'd5);
        send_request(KIND_RELEASE, 12'd2,    13'd3);
        send_request(KIND_ALLOC,   12'd0,    13'd3);
        send_request(KIND_ALLOC,   12'd0,    13'd4);
        send_request(KIND_ALLOC,   12'd4095, 13'd4097);
        send_request(KIND_RESERVE, 12'd4095, 13'd4096);
        send_request(KIND_RELEASE, 12'd0,    13'd4096);

        foreach (limits[p]) begin
            write_page_limit(limits[p]);
            repeat (PHASE_ITEMS) random_request();
        end

        if (start)
            start <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
